// File: rtl/rnk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnk_pkg
// Shared constants, types and state codes of the rank transform unit.
// ----------------------------------------------------------------------------
package rnk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int VAL_W     = 32;
  localparam int RANK_W    = 7;
  localparam int CNT_W     = $clog2(MAX_ITEMS);
  localparam int NUM_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [NUM_W-1:0] NUM_ONE  = NUM_W'(1);
  localparam logic [NUM_W-1:0] NUM_MAX  = NUM_W'(MAX_ITEMS);
  localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
    logic [CNT_W-1:0]        cnt;
  } token_t;

  typedef struct packed {
    logic             occ;
    logic [CNT_W-1:0] cnt;
  } cell_stat_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/rnk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnk_cell
// One compare cell: holds a stored value and its count of smaller values, and
// while occupied passes a traveling request token to the next cell each cycle.
// ----------------------------------------------------------------------------
module rnk_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rnk_pkg::cell_ctrl_t ctrl,
  input  rnk_pkg::token_t     tok_in,
  output rnk_pkg::token_t     tok_out,
  input  rnk_pkg::cell_stat_t nbr_in,
  output rnk_pkg::cell_stat_t stat_out
);

  logic                             occ_r, occ_nxt;
  logic signed [rnk_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [rnk_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  rnk_pkg::token_t                  tok_r, tok_nxt;

  always_comb begin
    occ_nxt     = occ_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    tok_nxt     = tok_in;
    tok_nxt.vld = 1'b0;
    if (ctrl.shift) begin
      occ_nxt = nbr_in.occ;
      cnt_nxt = nbr_in.cnt;
    end else if (tok_in.vld) begin
      if (occ_r) begin
        // compare and pass the token on
        tok_nxt.vld = 1'b1;
        if ($signed(val_r) < $signed(tok_in.val)) begin
          tok_nxt.cnt = tok_in.cnt + rnk_pkg::CNT_ONE;
        end
        if ($signed(tok_in.val) < $signed(val_r)) begin
          cnt_nxt = cnt_r + rnk_pkg::CNT_ONE;
        end
      end else begin
        // lodge in the first empty cell
        occ_nxt = 1'b1;
        val_nxt = tok_in.val;
        cnt_nxt = tok_in.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    cnt_r     <= cnt_nxt;
    tok_r.val <= tok_nxt.val;
    tok_r.cnt <= tok_nxt.cnt;
    if (!rst_n) begin
      occ_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
  end

  assign tok_out      = tok_r;
  assign stat_out.occ = occ_r;
  assign stat_out.cnt = cnt_r;

endmodule

// File: rtl/rnk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnk_ctrl
// Batch sequencer: load, settle of the last token, and drain of the ranks.
// ----------------------------------------------------------------------------
module rnk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                inject,
  input  logic                tok_busy,
  input  logic                head_occ,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                dropped,
  output rnk_pkg::cell_ctrl_t cell_ctrl
);

  rnk_pkg::state_t           state_r, state_nxt;
  logic [rnk_pkg::NUM_W-1:0] count_r, count_nxt;
  logic                      dropped_r, dropped_nxt;
  logic                      accept;
  logic                      full;

  assign full   = (count_r == rnk_pkg::NUM_MAX);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnk_pkg::ST_LOAD: begin
        if (accept && in_last) state_nxt = rnk_pkg::ST_SETTLE;
      end
      rnk_pkg::ST_SETTLE: begin
        if (!tok_busy) state_nxt = rnk_pkg::ST_DRAIN;
      end
      rnk_pkg::ST_DRAIN: begin
        if (!head_occ) state_nxt = rnk_pkg::ST_LOAD;
      end
      default: state_nxt = rnk_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    count_nxt       = count_r;
    dropped_nxt     = dropped_r;
    case (state_r)
      rnk_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          if (full) dropped_nxt = 1'b1;
          else      count_nxt   = count_r + rnk_pkg::NUM_ONE;
        end
      end
      rnk_pkg::ST_SETTLE: begin
      end
      rnk_pkg::ST_DRAIN: begin
        out_valid = head_occ;
        if (!head_occ) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    inject          = accept && !full;
    cell_ctrl.shift = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rnk_pkg::ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign dropped = dropped_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result side open together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rnk_pkg::NUM_MAX)
    else $error("element count beyond capacity");

  a_last_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (state_r == rnk_pkg::ST_SETTLE))
    else $error("last request did not close the batch");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dropped_r) |-> (count_r == rnk_pkg::NUM_MAX))
    else $error("element dropped below capacity");

endmodule

// File: rtl/rank_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_transform_unit
// Rank transform of a batch of signed 32-bit values through a row of cells.
// ----------------------------------------------------------------------------
// Values load one per cycle while the block is loading; each enters a row of
// MAX_ITEMS compare cells and walks one cell per cycle until it settles in the
// first free cell, counting the stored values below it while each stored value
// counts the newcomers below itself. After the request marked last, the block
// waits until that value has walked to its cell, then shifts out one rank per
// cycle while the receiver is ready, in load order, rank 1 for the smallest
// and equal values sharing a rank. Values beyond MAX_ITEMS are dropped and
// every rank of that batch carries overflow.
// ----------------------------------------------------------------------------
module rank_transform_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rnk_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rnk_pkg::RANK_W-1:0]        out_rank,
  output logic                              out_last_res,
  output logic                              out_overflow
);

  rnk_pkg::token_t     tok_chain  [rnk_pkg::MAX_ITEMS+1];
  rnk_pkg::cell_stat_t stat_chain [rnk_pkg::MAX_ITEMS+1];
  rnk_pkg::cell_ctrl_t cell_ctrl;
  logic                inject;
  logic                tok_busy;
  logic                dropped;

  assign tok_chain[0].vld = inject;
  assign tok_chain[0].val = in_value;
  assign tok_chain[0].cnt = '0;
  assign stat_chain[rnk_pkg::MAX_ITEMS] = '0;

  for (genvar k = 0; k < rnk_pkg::MAX_ITEMS; k++) begin : g_cell
    rnk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .tok_in   (tok_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .nbr_in   (stat_chain[k+1]),
      .stat_out (stat_chain[k])
    );
  end

  always_comb begin
    tok_busy = 1'b0;
    for (int k = 1; k <= rnk_pkg::MAX_ITEMS; k++) begin
      tok_busy = tok_busy | tok_chain[k].vld;
    end
  end

  rnk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .inject    (inject),
    .tok_busy  (tok_busy),
    .head_occ  (stat_chain[0].occ),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dropped   (dropped),
    .cell_ctrl (cell_ctrl)
  );

  assign out_rank     = {{(rnk_pkg::RANK_W-rnk_pkg::CNT_W){1'b0}}, stat_chain[0].cnt}
                        + rnk_pkg::RANK_ONE;
  assign out_last_res = !stat_chain[1].occ;
  assign out_overflow = dropped;

endmodule

// File: test/rank_transform_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_transform_unit_test
// Self-checking bench for the batch rank transform unit.
// ----------------------------------------------------------------------------
// Batches of signed values are streamed into the block. A scoreboard ranks
// each completed batch on its own and matches every rank it expects against
// the ranks that the block returns. The directed batches cover extremes,
// duplicates and single-value batches. The random batches add batches that
// fill the block exactly and batches that overflow it. Gaps on both sides are
// random, and the receiver once holds off for a long stretch.
// ----------------------------------------------------------------------------
module rank_transform_unit_test;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_RESULT = 40;
  localparam int DIR_COUNT = 18;

  typedef logic signed [rnk_pkg::VAL_W-1:0] value_t;

  typedef struct packed {
    logic [rnk_pkg::RANK_W-1:0] rank;
    logic                       last_res;
    logic                       overflow;
  } rank_result_t;

  class rank_scoreboard;
    value_t       batch_values[$];
    bit           batch_dropped;
    rank_result_t ranks_due[$];
    int           errors;

    function new();
      batch_dropped = 0;
      errors = 0;
    endfunction

    function void note_request(value_t value, bit last);
      rank_result_t r;
      int n;
      int smaller;
      if (batch_values.size() < rnk_pkg::MAX_ITEMS) begin
        batch_values.push_back(value);
      end else begin
        batch_dropped = 1;
      end
      if (!last) return;
      n = batch_values.size();
      for (int i = 0; i < n; i++) begin
        smaller = 0;
        for (int j = 0; j < n; j++) begin
          if (batch_values[j] < batch_values[i]) smaller++;
        end
        r.rank = rnk_pkg::RANK_W'(smaller + 1);
        r.last_res = (i == n - 1);
        r.overflow = batch_dropped;
        ranks_due.push_back(r);
      end
      batch_values.delete();
      batch_dropped = 0;
    endfunction

    function void check_result(logic [rnk_pkg::RANK_W-1:0] rank, logic last_res,
                               logic overflow);
      rank_result_t exp_r;
      if (ranks_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rank %0d last %0b overflow %0b",
                 $time, rank, last_res, overflow);
        errors++;
        return;
      end
      exp_r = ranks_due.pop_front();
      if (rank !== exp_r.rank) begin
        $display("%0t: rank mismatch, expected %0d, actual %0d", $time, exp_r.rank, rank);
        errors++;
      end
      if (last_res !== exp_r.last_res) begin
        $display("%0t: last_res mismatch, expected %0b, actual %0b",
                 $time, exp_r.last_res, last_res);
        errors++;
      end
      if (overflow !== exp_r.overflow) begin
        $display("%0t: overflow mismatch, expected %0b, actual %0b",
                 $time, exp_r.overflow, overflow);
        errors++;
      end
    endfunction

    function int pending();
      return ranks_due.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  value_t                     in_value;
  logic                       in_last;
  logic                       out_valid;
  logic                       out_ready;
  logic [rnk_pkg::RANK_W-1:0] out_rank;
  logic                       out_last_res;
  logic                       out_overflow;

  rank_scoreboard sb;
  bit             tx_burst;
  bit             rx_burst;
  int             idle_cycles = 0;
  int             results_seen;

  value_t dir_value [DIR_COUNT] = '{
    32'sd5,
    32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1, -32'sd2,
    32'sd3, 32'sd3, -32'sd7, 32'sd3, -32'sd7,
    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
    32'sd10, -32'sd10
  };
  bit dir_last [DIR_COUNT] = '{
    1,
    0, 0, 0, 0, 0, 1,
    0, 0, 0, 0, 1,
    0, 0, 0, 1,
    0, 1
  };

  rank_transform_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rank     (out_rank),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t pick_value(int mode);
    int r;
    case (mode)
      0: return value_t'($urandom);
      1: return value_t'($urandom_range(0, 8)) - 32'sd4;
      default: begin
        r = $urandom_range(0, 6);
        case (r)
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return 32'sh80000001;
          3: return 32'sd0;
          4: return -32'sd1;
          default: return value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_request(value_t value, bit last);
    int gap;
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(value, last);
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold
  initial begin
    int stall_left;
    int gap_left;
    stall_left = 0;
    gap_left = 0;
    rx_burst = 0;
    results_seen = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_rank, out_last_res, out_overflow);
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) stall_left = HOLD_CYCLES;
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_burst) gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rank_transform_unit_test failed");
        $finish;
      end
    end
  end

  initial begin
    int total;
    int bsize;
    int vmode;
    int b;
    sb = new();
    tx_burst = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) send_request(dir_value[i], dir_last[i]);

    // random batches; batch 2 fills the row, batch 5 overflows and drops its last two values
    total = 0;
    b = 0;
    while (total < 162) begin
      if (b == 2) begin
        bsize = rnk_pkg::MAX_ITEMS;
      end else if (b == 5) begin
        bsize = rnk_pkg::MAX_ITEMS + 2;
      end else if ($urandom_range(0, 9) == 0) begin
        bsize = $urandom_range(9, 24);
      end else begin
        bsize = $urandom_range(1, 8);
      end
      vmode = $urandom_range(0, 2);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < bsize; i++) send_request(pick_value(vmode), i == bsize - 1);
      total += bsize;
      if (b == 3) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      b++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (4 * rnk_pkg::MAX_ITEMS) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rank_transform_unit_test passed");
    end else begin
      $display("rank_transform_unit_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rnk_pkg.sv
rtl/rnk_cell.sv
rtl/rnk_ctrl.sv
rtl/rank_transform_unit.sv
test/rank_transform_unit_test.sv
